>>> design/qrr_pkg.sv
// Shared constants and types for the quadratic real-root solver.
package qrr_pkg;

    localparam int COEF_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF = 16;
    localparam int ROOT_BITS     = 33;

    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;

    typedef struct packed {
        logic [1:0] root_count;
        logic       degenerate;
        logic       end_of_session;
    } qrr_flags_t;

    localparam int FLAGS_W = $bits(qrr_flags_t);

endpackage

>>> design/quadratic_real_roots.sv
// Top level of the quadratic real-root solver: discriminant, root and divide pipeline.
// The result is registered after a multiply stage, a discriminant stage, one square-root cell
// per root bit, a numerator stage, one divider cell per quotient bit and an output register.
// Throughput: one item per cycle; a stalled result freezes the whole pipeline.
// Reset clears all valid bits; payload registers are not reset.
module quadratic_real_roots #(
    parameter int COEF_BITS = qrr_pkg::COEF_BITS_DEF,
    parameter int FRAC_BITS = qrr_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              coef_valid,
    output logic                              coef_stall,
    input  logic signed [COEF_BITS-1:0]       coef_a,
    input  logic signed [COEF_BITS-1:0]       coef_b,
    input  logic signed [COEF_BITS-1:0]       coef_c,
    output logic                              root_valid,
    input  logic                              root_stall,
    output logic [1:0]                        root_count,
    output logic signed [qrr_pkg::ROOT_BITS-1:0] root_first,
    output logic signed [qrr_pkg::ROOT_BITS-1:0] root_second,
    output logic                              degenerate,
    output logic                              end_of_session
);
    import qrr_pkg::*;

    localparam int CB   = COEF_BITS;
    localparam int PW   = 2 * CB;
    localparam int DW   = 2 * CB + 1;
    localparam int SW   = CB + FRAC_BITS + 1;
    localparam int RDW  = 2 * SW;
    localparam int NBW  = CB + FRAC_BITS + 1;
    localparam int NW   = CB + FRAC_BITS + 3;
    localparam int NMW  = CB + FRAC_BITS + 2;
    localparam int DVW  = CB + 1;
    localparam int S1W  = FLAGS_W + NBW + 1 + DVW;
    localparam int S2W  = FLAGS_W + 2;
    localparam int QW   = NMW + 1;
    localparam int EW   = ((QW > ROOT_BITS) ? QW : ROOT_BITS) + 1;
    localparam logic signed [EW-1:0] RMAX = (EW'(1) <<< (ROOT_BITS - 1)) - EW'(1);
    localparam logic signed [EW-1:0] RMIN = -(EW'(1) <<< (ROOT_BITS - 1));

    logic en;

    // input magnitudes
    logic [CB-1:0] am;
    logic [CB-1:0] bm;
    logic [CB-1:0] cm;

    // multiply stage
    logic              m_valid_reg;
    logic [PW-1:0]     b2_reg;
    logic [PW-1:0]     p_reg;
    logic              ac_pos_reg;
    logic signed [CB-1:0] b_reg;
    logic              a_neg_reg;
    logic [DVW-1:0]    dvm_reg;
    logic              eos_reg;
    logic              degen_reg;

    // discriminant stage
    logic [PW+1:0]     p4;
    logic [DW:0]       d_sum;
    logic [DW:0]       d_dif;
    logic              d_neg;
    logic [DW-1:0]     d_mag;
    logic signed [CB:0] b_neg;
    logic signed [NBW-1:0] nb;
    qrr_flags_t        d_flags;

    logic              d_valid_reg;
    logic [RDW-1:0]    rad_reg;
    logic [S1W-1:0]    d_side_reg;

    // square-root chain
    logic              sq_valid [SW+1];
    logic [RDW-1:0]    sq_rad   [SW+1];
    logic [SW-1:0]     sq_root  [SW+1];
    logic [SW+2:0]     sq_rem   [SW+1];
    logic [S1W-1:0]    sq_side  [SW+1];

    // numerator stage
    qrr_flags_t        sq_flags;
    logic signed [NBW-1:0] sq_nb;
    logic              sq_den_neg;
    logic [DVW-1:0]    sq_dvm;
    logic signed [NW-1:0] n1;
    logic signed [NW-1:0] n2;
    logic [NW-1:0]     n1_abs;
    logic [NW-1:0]     n2_abs;

    logic              n_valid_reg;
    logic [NMW-1:0]    n1m_reg;
    logic [NMW-1:0]    n2m_reg;
    logic [DVW-1:0]    n_dv_reg;
    logic [S2W-1:0]    n_side_reg;

    // divider chain
    logic              dc_valid [NMW+1];
    logic [NMW-1:0]    dc_dq1   [NMW+1];
    logic [NMW-1:0]    dc_dq2   [NMW+1];
    logic [DVW-1:0]    dc_rem1  [NMW+1];
    logic [DVW-1:0]    dc_rem2  [NMW+1];
    logic [DVW-1:0]    dc_dv    [NMW+1];
    logic [S2W-1:0]    dc_side  [NMW+1];

    // result stage
    qrr_flags_t        f_flags;
    logic              q1_neg;
    logic              q2_neg;
    logic signed [EW-1:0] q1;
    logic signed [EW-1:0] q2;
    logic signed [EW-1:0] q1_sat;
    logic signed [EW-1:0] q2_sat;

    logic              out_valid_reg;
    qrr_flags_t        out_flags_reg;
    logic signed [ROOT_BITS-1:0] first_reg;
    logic signed [ROOT_BITS-1:0] second_reg;

    assign en         = !(out_valid_reg && root_stall);
    assign coef_stall = !en;

    always_comb
    begin
        am = coef_a[CB-1] ? CB'(-coef_a) : CB'(coef_a);
        bm = coef_b[CB-1] ? CB'(-coef_b) : CB'(coef_b);
        cm = coef_c[CB-1] ? CB'(-coef_c) : CB'(coef_c);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            n_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg   <= coef_valid;
            d_valid_reg   <= m_valid_reg;
            n_valid_reg   <= sq_valid[SW];
            out_valid_reg <= dc_valid[NMW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b2_reg     <= PW'(bm) * PW'(bm);
            p_reg      <= PW'(am) * PW'(cm);
            ac_pos_reg <= (coef_c != '0) && (coef_a[CB-1] == coef_c[CB-1]);
            b_reg      <= coef_b;
            a_neg_reg  <= coef_a[CB-1];
            dvm_reg    <= {am, 1'b0};
            eos_reg    <= (coef_a == '0) && (coef_b == '0) && (coef_c == '0);
            degen_reg  <= (coef_a == '0) && !((coef_b == '0) && (coef_c == '0));
        end
    end

    always_comb
    begin
        p4    = {p_reg, 2'b00};
        d_sum = (DW+1)'(b2_reg) + (DW+1)'(p4);
        d_dif = (DW+1)'(b2_reg) - (DW+1)'(p4);
        d_neg = ac_pos_reg && ((DW+1)'(p4) > (DW+1)'(b2_reg));
        d_mag = ac_pos_reg ? d_dif[DW-1:0] : d_sum[DW-1:0];
        b_neg = -((CB+1)'(b_reg));
        nb    = NBW'(b_neg) <<< FRAC_BITS;
        d_flags.end_of_session = eos_reg;
        d_flags.degenerate     = degen_reg;
        if (eos_reg || degen_reg || d_neg)
        begin
            d_flags.root_count = CNT_NONE;
        end
        else if (d_mag == '0)
        begin
            d_flags.root_count = CNT_ONE;
        end
        else
        begin
            d_flags.root_count = CNT_TWO;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg    <= RDW'(d_mag) << (2 * FRAC_BITS);
            d_side_reg <= {d_flags, nb, a_neg_reg, dvm_reg};
        end
    end

    assign sq_valid[0] = d_valid_reg;
    assign sq_rad[0]   = rad_reg;
    assign sq_root[0]  = '0;
    assign sq_rem[0]   = '0;
    assign sq_side[0]  = d_side_reg;

    for (genvar i = 0; i < SW; i++)
    begin : g_sqrt
        qrr_sqrt_cell #(
            .SW     (SW),
            .RDW    (RDW),
            .SIDE_W (S1W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (sq_valid[i]),
            .in_rad    (sq_rad[i]),
            .in_root   (sq_root[i]),
            .in_rem    (sq_rem[i]),
            .in_side   (sq_side[i]),
            .out_valid (sq_valid[i+1]),
            .out_rad   (sq_rad[i+1]),
            .out_root  (sq_root[i+1]),
            .out_rem   (sq_rem[i+1]),
            .out_side  (sq_side[i+1])
        );
    end

    always_comb
    begin
        {sq_flags, sq_nb, sq_den_neg, sq_dvm} = sq_side[SW];
        n1     = NW'(sq_nb) + NW'($signed({1'b0, sq_root[SW]}));
        n2     = NW'(sq_nb) - NW'($signed({1'b0, sq_root[SW]}));
        n1_abs = n1[NW-1] ? NW'(-n1) : NW'(n1);
        n2_abs = n2[NW-1] ? NW'(-n2) : NW'(n2);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1m_reg    <= n1_abs[NMW-1:0];
            n2m_reg    <= n2_abs[NMW-1:0];
            n_dv_reg   <= sq_dvm;
            n_side_reg <= {sq_flags, n1[NW-1] ^ sq_den_neg, n2[NW-1] ^ sq_den_neg};
        end
    end

    assign dc_valid[0] = n_valid_reg;
    assign dc_dq1[0]   = n1m_reg;
    assign dc_dq2[0]   = n2m_reg;
    assign dc_rem1[0]  = '0;
    assign dc_rem2[0]  = '0;
    assign dc_dv[0]    = n_dv_reg;
    assign dc_side[0]  = n_side_reg;

    for (genvar j = 0; j < NMW; j++)
    begin : g_div
        qrr_div_cell #(
            .NMW    (NMW),
            .DVW    (DVW),
            .SIDE_W (S2W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (dc_valid[j]),
            .in_dq1    (dc_dq1[j]),
            .in_dq2    (dc_dq2[j]),
            .in_rem1   (dc_rem1[j]),
            .in_rem2   (dc_rem2[j]),
            .in_dv     (dc_dv[j]),
            .in_side   (dc_side[j]),
            .out_valid (dc_valid[j+1]),
            .out_dq1   (dc_dq1[j+1]),
            .out_dq2   (dc_dq2[j+1]),
            .out_rem1  (dc_rem1[j+1]),
            .out_rem2  (dc_rem2[j+1]),
            .out_dv    (dc_dv[j+1]),
            .out_side  (dc_side[j+1])
        );
    end

    always_comb
    begin
        {f_flags, q1_neg, q2_neg} = dc_side[NMW];
        q1 = q1_neg ? -$signed(EW'(dc_dq1[NMW])) : $signed(EW'(dc_dq1[NMW]));
        q2 = q2_neg ? -$signed(EW'(dc_dq2[NMW])) : $signed(EW'(dc_dq2[NMW]));
        priority if (q1 > RMAX)
        begin
            q1_sat = RMAX;
        end
        else if (q1 < RMIN)
        begin
            q1_sat = RMIN;
        end
        else
        begin
            q1_sat = q1;
        end
        priority if (q2 > RMAX)
        begin
            q2_sat = RMAX;
        end
        else if (q2 < RMIN)
        begin
            q2_sat = RMIN;
        end
        else
        begin
            q2_sat = q2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_flags_reg <= f_flags;
            if (f_flags.root_count == CNT_NONE)
            begin
                first_reg  <= '0;
                second_reg <= '0;
            end
            else
            begin
                first_reg  <= q1_sat[ROOT_BITS-1:0];
                second_reg <= q2_sat[ROOT_BITS-1:0];
            end
        end
    end

    assign root_valid     = out_valid_reg;
    assign root_count     = out_flags_reg.root_count;
    assign degenerate     = out_flags_reg.degenerate;
    assign end_of_session = out_flags_reg.end_of_session;
    assign root_first     = first_reg;
    assign root_second    = second_reg;

endmodule

>>> design/qrr_sqrt_cell.sv
// One digit step of the pipelined integer square root, producing one root bit.
module qrr_sqrt_cell #(
    parameter int SW     = 33,
    parameter int RDW    = 66,
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [RDW-1:0]    in_rad,
    input  logic [SW-1:0]     in_root,
    input  logic [SW+2:0]     in_rem,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [RDW-1:0]    out_rad,
    output logic [SW-1:0]     out_root,
    output logic [SW+2:0]     out_rem,
    output logic [SIDE_W-1:0] out_side
);

    logic [SW+2:0]     rem_sh;
    logic [SW+2:0]     trial;
    logic              ge;
    logic              valid_reg;
    logic [RDW-1:0]    rad_reg;
    logic [SW-1:0]     root_reg;
    logic [SW+2:0]     rem_reg;
    logic [SIDE_W-1:0] side_reg;

    always_comb
    begin
        rem_sh = {in_rem[SW:0], in_rad[RDW-1 -: 2]};
        trial  = {1'b0, in_root, 2'b01};
        ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= {in_rad[RDW-3:0], 2'b00};
            root_reg <= {in_root[SW-2:0], ge};
            rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rad   = rad_reg;
    assign out_root  = root_reg;
    assign out_rem   = rem_reg;
    assign out_side  = side_reg;

endmodule

>>> design/qrr_div_cell.sv
// One quotient bit of the two restoring dividers that share a divisor.
module qrr_div_cell #(
    parameter int NMW    = 34,
    parameter int DVW    = 17,
    parameter int SIDE_W = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NMW-1:0]    in_dq1,
    input  logic [NMW-1:0]    in_dq2,
    input  logic [DVW-1:0]    in_rem1,
    input  logic [DVW-1:0]    in_rem2,
    input  logic [DVW-1:0]    in_dv,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [NMW-1:0]    out_dq1,
    output logic [NMW-1:0]    out_dq2,
    output logic [DVW-1:0]    out_rem1,
    output logic [DVW-1:0]    out_rem2,
    output logic [DVW-1:0]    out_dv,
    output logic [SIDE_W-1:0] out_side
);

    logic [DVW:0]      sh1;
    logic [DVW:0]      sh2;
    logic [DVW:0]      dv_ext;
    logic              ge1;
    logic              ge2;
    logic [DVW:0]      diff1;
    logic [DVW:0]      diff2;
    logic              valid_reg;
    logic [NMW-1:0]    dq1_reg;
    logic [NMW-1:0]    dq2_reg;
    logic [DVW-1:0]    rem1_reg;
    logic [DVW-1:0]    rem2_reg;
    logic [DVW-1:0]    dv_reg;
    logic [SIDE_W-1:0] side_reg;

    always_comb
    begin
        sh1    = {in_rem1, in_dq1[NMW-1]};
        sh2    = {in_rem2, in_dq2[NMW-1]};
        dv_ext = {1'b0, in_dv};
        ge1    = (sh1 >= dv_ext);
        ge2    = (sh2 >= dv_ext);
        diff1  = ge1 ? (sh1 - dv_ext) : sh1;
        diff2  = ge2 ? (sh2 - dv_ext) : sh2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dq1_reg  <= {in_dq1[NMW-2:0], ge1};
            dq2_reg  <= {in_dq2[NMW-2:0], ge2};
            rem1_reg <= diff1[DVW-1:0];
            rem2_reg <= diff2[DVW-1:0];
            dv_reg   <= in_dv;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_dq1   = dq1_reg;
    assign out_dq2   = dq2_reg;
    assign out_rem1  = rem1_reg;
    assign out_rem2  = rem2_reg;
    assign out_dv    = dv_reg;
    assign out_side  = side_reg;

endmodule
